// File: rtl/core/rdct_pkg.sv
`default_nettype none
package rdct_pkg;

   // Table and message geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int MESSAGE_CHARS = 5;
   localparam int MSG_BITS      = 8 * MESSAGE_CHARS;

   // Fixed field widths of the transfer
   localparam int WORD_W     = 32;
   localparam int CHAR_W     = 8;
   localparam int OUT_MSG_W  = 40;
   localparam int OUTCOME_W  = 3;
   localparam int ENTRY_W    = 4 * WORD_W;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Result classification
   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NEW_CLIENT  = 3'd0,
      OUT_NEW_REQUEST = 3'd1,
      OUT_DUPLICATE   = 3'd2,
      OUT_STALE       = 3'd3,
      OUT_DROPPED     = 3'd4
   } outcome_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic drop;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/core/rdct_ctrl.sv
`default_nettype none
module rdct_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire rdct_pkg::sts_type sts,
   output rdct_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.scan    = 1'b0;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.drop || sts.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/rdct_datapath.sv
`default_nettype none
module rdct_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rdct_pkg::cmd_type              cmd,
   output rdct_pkg::sts_type                   sts,
   input  wire logic [rdct_pkg::WORD_W-1:0]    in_client_addr,
   input  wire logic [rdct_pkg::WORD_W-1:0]    in_incarnation,
   input  wire logic [rdct_pkg::WORD_W-1:0]    in_client_number,
   input  wire logic [rdct_pkg::WORD_W-1:0]    in_request_number,
   input  wire logic [rdct_pkg::CHAR_W-1:0]    in_character,
   input  wire logic                           in_drop_request,
   input  wire logic                           in_suppress_reply,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic                                out_reply_valid,
   output logic [rdct_pkg::OUT_MSG_W-1:0]      out_message,
   output logic [rdct_pkg::OUTCOME_W-1:0]      out_outcome
);

   localparam logic [rdct_pkg::IDX_W:0] SCAN_END = (rdct_pkg::IDX_W+1)'(rdct_pkg::TABLE_ENTRIES);
   localparam logic [rdct_pkg::IDX_W-1:0] LAST_IDX =
      rdct_pkg::IDX_W'(rdct_pkg::TABLE_ENTRIES - 1);

   // Request held for the whole transaction
   logic [rdct_pkg::WORD_W-1:0] addr_ff, inc_ff, cli_ff, reqn_ff;
   logic [rdct_pkg::CHAR_W-1:0] ch_ff;
   logic                        drop_ff, quiet_ff;

   // Client table and its valid bits
   logic [rdct_pkg::ENTRY_W-1:0]     tbl_mem [rdct_pkg::TABLE_ENTRIES];
   logic [rdct_pkg::ENTRY_W-1:0]     rd_data_ff;
   logic [rdct_pkg::TABLE_ENTRIES-1:0] valid_ff;
   logic [rdct_pkg::IDX_W-1:0]       ptr_ff;
   logic [rdct_pkg::MSG_BITS-1:0]    msg_ff;

   // Scan state
   logic [rdct_pkg::IDX_W:0]    scan_idx_ff;
   logic [rdct_pkg::IDX_W-1:0]  cmp_idx_ff;
   logic                        cmp_vld_ff;
   logic                        hit_ff;
   logic [rdct_pkg::IDX_W-1:0]  hit_idx_ff;
   logic [rdct_pkg::WORD_W-1:0] hit_last_ff;

   // Output register
   logic                           out_valid_ff;
   logic                           out_reply_ff;
   logic [rdct_pkg::OUT_MSG_W-1:0] out_msg_ff;
   logic [rdct_pkg::OUTCOME_W-1:0] out_outcome_ff;

   logic                          scan_rd;
   logic                          key_match;
   logic [rdct_pkg::IDX_W-1:0]    rd_addr;
   logic                          stale, dup;
   rdct_pkg::outcome_type         outcome;
   logic                          reply, shift, wr_en, ins;
   logic [rdct_pkg::IDX_W-1:0]    wr_addr;
   logic [rdct_pkg::MSG_BITS-1:0] msg_in;
   logic [rdct_pkg::IDX_W-1:0]    ptr_in;

   assign scan_rd   = cmd.scan && (scan_idx_ff != SCAN_END);
   assign rd_addr   = scan_idx_ff[rdct_pkg::IDX_W-1:0];
   assign key_match = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                      (rd_data_ff[rdct_pkg::ENTRY_W-1:rdct_pkg::WORD_W] ==
                       {addr_ff, inc_ff, cli_ff});

   assign sts.drop      = drop_ff;
   assign sts.scan_done = (scan_idx_ff == SCAN_END) && !cmp_vld_ff;
   assign sts.out_free  = !out_valid_ff || out_ready;

   // Classify the request and decide the updates
   always_comb begin
      stale   = $signed(reqn_ff) < $signed(hit_last_ff);
      dup     = reqn_ff == hit_last_ff;
      outcome = rdct_pkg::OUT_DROPPED;
      reply   = 1'b0;
      shift   = 1'b0;
      wr_en   = 1'b0;
      ins     = 1'b0;
      if (!drop_ff) begin
         if (hit_ff) begin
            if (stale) begin
               outcome = rdct_pkg::OUT_STALE;
            end else if (dup) begin
               outcome = rdct_pkg::OUT_DUPLICATE;
               reply   = !quiet_ff;
            end else begin
               outcome = rdct_pkg::OUT_NEW_REQUEST;
               reply   = !quiet_ff;
               shift   = 1'b1;
               wr_en   = 1'b1;
            end
         end else begin
            outcome = rdct_pkg::OUT_NEW_CLIENT;
            reply   = 1'b1;
            shift   = 1'b1;
            wr_en   = 1'b1;
            ins     = 1'b1;
         end
      end
      wr_addr = hit_ff ? hit_idx_ff : ptr_ff;
      msg_in  = shift ? rdct_pkg::MSG_BITS'({msg_ff, ch_ff}) : msg_ff;
      ptr_in  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff  <= in_client_addr;
         inc_ff   <= in_incarnation;
         cli_ff   <= in_client_number;
         reqn_ff  <= in_request_number;
         ch_ff    <= in_character;
         drop_ff  <= in_drop_request;
         quiet_ff <= in_suppress_reply;
      end
   end

   // Table memory: one registered read, one write
   always_ff @(posedge clock) begin
      if (scan_rd) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
      if (cmd.commit && wr_en) begin
         tbl_mem[wr_addr] <= {addr_ff, inc_ff, cli_ff, reqn_ff};
      end
   end

   // Scan the table one entry a cycle, first match wins
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (cmd.capture) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (cmd.scan) begin
         cmp_vld_ff <= scan_rd;
         if (scan_rd) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (key_match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_rd) begin
         cmp_idx_ff <= rd_addr;
      end
      if (cmd.scan && key_match && !hit_ff) begin
         hit_idx_ff  <= cmp_idx_ff;
         hit_last_ff <= rd_data_ff[rdct_pkg::WORD_W-1:0];
      end
   end

   // Commit state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
         msg_ff   <= {rdct_pkg::MESSAGE_CHARS{rdct_pkg::SPACE_CHAR}};
      end else if (cmd.commit) begin
         msg_ff <= msg_in;
         if (ins) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= ptr_in;
         end
      end
   end

   // Output register, holds until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_reply_ff   <= reply;
         out_msg_ff     <= reply ? rdct_pkg::OUT_MSG_W'(msg_in) : '0;
         out_outcome_ff <= outcome;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_reply_valid = out_reply_ff;
   assign out_message     = out_msg_ff;
   assign out_outcome     = out_outcome_ff;

   a_commit_loads_output: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_valid_ff)
      else $error("commit did not present a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!out_valid_ff || out_ready))
      else $error("result overwritten before its transfer");

   a_silent_zero_msg: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_reply_ff) |-> (out_msg_ff == '0))
      else $error("message nonzero without reply");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_IDX)
      else $error("insert pointer out of range");

endmodule
`default_nettype wire

// File: rtl/core/request_dedup_client_table_unit.sv
`default_nettype none
// Request de-duplicating client table. Each request transfer on req_ is looked
// up by its key (client address, incarnation, client number) in a table of
// rdct_pkg::TABLE_ENTRIES clients; exactly one result transfer on rsp_ follows.
// A lower request number is stale, an equal one a duplicate answered with the
// current message, a higher one or an unknown client shifts the character into
// the shared message and replies; known clients may suppress the reply, unknown
// ones are always answered and are inserted round robin. One request is
// processed at a time; the table scan reads one entry per cycle from a memory
// with one registered read port and one write port, and a dropped request does
// not wait for the scan. A finished result waits in an output register, and the
// next request is accepted while it waits.
module request_dedup_client_table_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // client_addr[31:0], incarnation[63:32], client_number[95:64],
   // request_number[127:96], character[135:128], drop_request[136],
   // suppress_reply[137], zero fill
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // reply_valid[0], message[40:1], outcome[43:41], zero fill
   output logic [47:0]       rsp_tdata
);

   rdct_pkg::cmd_type cmd;
   rdct_pkg::sts_type sts;

   logic                           reply_valid;
   logic [rdct_pkg::OUT_MSG_W-1:0] message;
   logic [rdct_pkg::OUTCOME_W-1:0] outcome;

   rdct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rdct_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .in_client_addr    (req_tdata[31:0]),
      .in_incarnation    (req_tdata[63:32]),
      .in_client_number  (req_tdata[95:64]),
      .in_request_number (req_tdata[127:96]),
      .in_character      (req_tdata[135:128]),
      .in_drop_request   (req_tdata[136]),
      .in_suppress_reply (req_tdata[137]),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_reply_valid   (reply_valid),
      .out_message       (message),
      .out_outcome       (outcome)
   );

   // Pack the result transfer
   assign rsp_tdata = {4'b0000, outcome, message, reply_valid};

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int N_RANDOM  = 1700;
   localparam int N_TAIL    = 200;
   localparam int POOL_KEYS = 24;

   // One request as the stimulus sees it, plus its pacing
   typedef struct {
      logic [rdct_pkg::WORD_W-1:0]        addr;
      logic signed [rdct_pkg::WORD_W-1:0] incarnation;
      logic signed [rdct_pkg::WORD_W-1:0] client;
      logic signed [rdct_pkg::WORD_W-1:0] req_num;
      logic [rdct_pkg::CHAR_W-1:0]        ch;
      logic                               drop;
      logic                               quiet;
      int                                 gap;
      bit                                 drain;
   } client_request_type;

   // One result transfer
   typedef struct {
      logic                           reply;
      logic [rdct_pkg::OUT_MSG_W-1:0] message;
      rdct_pkg::outcome_type          outcome;
   } dedup_reply_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // client_addr, incarnation, client_number, request_number, character,
   // drop_request, suppress_reply, zero fill
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // reply_valid, message, outcome, zero fill
   logic [47:0]  rsp_tdata;

   request_dedup_client_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the client table and shared message
   logic                               tbl_valid [rdct_pkg::TABLE_ENTRIES];
   logic [rdct_pkg::WORD_W-1:0]        tbl_addr  [rdct_pkg::TABLE_ENTRIES];
   logic signed [rdct_pkg::WORD_W-1:0] tbl_inc   [rdct_pkg::TABLE_ENTRIES];
   logic signed [rdct_pkg::WORD_W-1:0] tbl_cli   [rdct_pkg::TABLE_ENTRIES];
   logic signed [rdct_pkg::WORD_W-1:0] tbl_last  [rdct_pkg::TABLE_ENTRIES];
   logic [rdct_pkg::MSG_BITS-1:0]      msg_shadow;
   logic [rdct_pkg::IDX_W-1:0]         ins_ptr;

   client_request_type pending[$];
   dedup_reply_type    expected_replies[$];
   client_request_type staged, in_flight;
   bit              staged_ok = 1'b0;
   int              idle_left = 0;
   int              stall_left = 0;
   int              n_accepted = 0;
   int              n_checked = 0;
   int              total_items = 0;
   int              cycle_cnt = 0;
   int              errors = 0;

   // Look the request up in the shadow table, update it, return the reply
   function automatic dedup_reply_type dedup_lookup(client_request_type r);
      dedup_reply_type rsp;
      int              hit;
      hit         = -1;
      rsp.reply   = 1'b0;
      rsp.message = '0;
      if (r.drop) begin
         rsp.outcome = rdct_pkg::OUT_DROPPED;
         return rsp;
      end
      for (int k = rdct_pkg::TABLE_ENTRIES - 1; k >= 0; k--)
         if (tbl_valid[k] && tbl_addr[k] == r.addr && tbl_inc[k] == r.incarnation &&
             tbl_cli[k] == r.client)
            hit = k;
      if (hit < 0) begin
         // unknown client: insert round robin, always reply
         tbl_valid[ins_ptr] = 1'b1;
         tbl_addr[ins_ptr]  = r.addr;
         tbl_inc[ins_ptr]   = r.incarnation;
         tbl_cli[ins_ptr]   = r.client;
         tbl_last[ins_ptr]  = r.req_num;
         ins_ptr            = ins_ptr + 1'b1;
         msg_shadow         = {msg_shadow[rdct_pkg::MSG_BITS-rdct_pkg::CHAR_W-1:0], r.ch};
         rsp.outcome        = rdct_pkg::OUT_NEW_CLIENT;
         rsp.reply          = 1'b1;
      end else if (r.req_num < tbl_last[hit]) begin
         rsp.outcome = rdct_pkg::OUT_STALE;
      end else if (r.req_num == tbl_last[hit]) begin
         rsp.outcome = rdct_pkg::OUT_DUPLICATE;
         rsp.reply   = !r.quiet;
      end else begin
         tbl_last[hit] = r.req_num;
         msg_shadow    = {msg_shadow[rdct_pkg::MSG_BITS-rdct_pkg::CHAR_W-1:0], r.ch};
         rsp.outcome   = rdct_pkg::OUT_NEW_REQUEST;
         rsp.reply     = !r.quiet;
      end
      if (rsp.reply)
         rsp.message = rdct_pkg::OUT_MSG_W'(msg_shadow);
      return rsp;
   endfunction

   task automatic push_request(input logic [rdct_pkg::WORD_W-1:0] addr,
                               input logic signed [rdct_pkg::WORD_W-1:0] incarnation,
                               input logic signed [rdct_pkg::WORD_W-1:0] client,
                               input logic signed [rdct_pkg::WORD_W-1:0] req_num,
                               input logic [rdct_pkg::CHAR_W-1:0] ch,
                               input logic drop, input logic quiet,
                               input int gap, input bit drain);
      client_request_type r;
      r.addr        = addr;
      r.incarnation = incarnation;
      r.client      = client;
      r.req_num     = req_num;
      r.ch          = ch;
      r.drop        = drop;
      r.quiet       = quiet;
      r.gap         = gap;
      r.drain       = drain;
      pending.push_back(r);
   endtask

   // Driver: record accepted transfers, then present the next request
   always @(posedge clock) begin : drive_requests
      logic launch;
      launch = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(dedup_lookup(in_flight));
            n_accepted <= n_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (!staged_ok && pending.size() > 0) begin
               staged    = pending.pop_front();
               staged_ok = 1'b1;
               idle_left = staged.gap;
            end
            if (staged_ok && idle_left > 0) begin
               idle_left--;
            end else if (staged_ok &&
                         !(staged.drain && (req_tvalid || n_accepted != n_checked))) begin
               in_flight = staged;
               staged_ok = 1'b0;
               launch    = 1'b1;
            end
            req_tvalid <= launch;
            if (launch)
               req_tdata <= {6'b0, in_flight.quiet, in_flight.drop, in_flight.ch,
                             in_flight.req_num, in_flight.client, in_flight.incarnation,
                             in_flight.addr};
         end
      end
   end

   // Monitor: check each result transfer, stall the result side in bursts
   always @(posedge clock) begin : check_replies
      dedup_reply_type                exp_rsp;
      logic                           got_reply;
      logic [rdct_pkg::OUT_MSG_W-1:0] got_msg;
      logic [rdct_pkg::OUTCOME_W-1:0] got_outcome;
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_reply   = rsp_tdata[0];
            got_msg     = rsp_tdata[rdct_pkg::OUT_MSG_W:1];
            got_outcome = rsp_tdata[rdct_pkg::OUT_MSG_W+rdct_pkg::OUTCOME_W:
                                    rdct_pkg::OUT_MSG_W+1];
            n_checked <= n_checked + 1;
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected result reply=%0b message=%h outcome=%0d",
                        $time, got_reply, got_msg, got_outcome);
               errors++;
            end else begin
               exp_rsp = expected_replies.pop_front();
               if (got_reply !== exp_rsp.reply) begin
                  $display("%0t: reply_valid expected %0b actual %0b",
                           $time, exp_rsp.reply, got_reply);
                  errors++;
               end
               if (got_msg !== exp_rsp.message) begin
                  $display("%0t: message expected %h actual %h",
                           $time, exp_rsp.message, got_msg);
                  errors++;
               end
               if (got_outcome !== exp_rsp.outcome) begin
                  $display("%0t: outcome expected %0d actual %0d",
                           $time, exp_rsp.outcome, got_outcome);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (n_accepted + N_TAIL < total_items && (cycle_cnt / 600) % 2 == 0 &&
                      $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Give up if the run hangs
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [rdct_pkg::WORD_W-1:0]        pool_addr [POOL_KEYS];
      logic signed [rdct_pkg::WORD_W-1:0] pool_inc  [POOL_KEYS];
      logic signed [rdct_pkg::WORD_W-1:0] pool_cli  [POOL_KEYS];
      logic signed [rdct_pkg::WORD_W-1:0] pool_last [POOL_KEYS];
      logic signed [rdct_pkg::WORD_W-1:0] num;
      logic                               drop, quiet;
      int                                 k, sel, gap;

      for (int i = 0; i < rdct_pkg::TABLE_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_addr[i]  = '0;
         tbl_inc[i]   = '0;
         tbl_cli[i]   = '0;
         tbl_last[i]  = '0;
      end
      msg_shadow = {rdct_pkg::MESSAGE_CHARS{rdct_pkg::SPACE_CHAR}};
      ins_ptr    = '0;

      // Directed: every outcome, signed extremes, drop and suppress corners
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd5, 8'h41, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd6, 8'h42, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd6, 8'h43, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd3, 8'h44, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd7, 8'h45, 1'b1, 1'b0, 0, 1'b0);
      // dropped request from an unknown client must not insert it
      push_request(32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 8'hFF,
                   1'b1, 1'b0, 0, 1'b0);
      push_request(32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 8'hFF,
                   1'b0, 1'b0, 0, 1'b0);
      push_request(32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 8'h80,
                   1'b0, 1'b0, 0, 1'b0);
      push_request(32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sd1, 8'h01,
                   1'b0, 1'b0, 0, 1'b0);
      // suppressed replies for a known client: new, duplicate, stale
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd8, 8'h5A, 1'b0, 1'b1, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd8, 8'h5B, 1'b0, 1'b1, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd2, 8'h5C, 1'b0, 1'b1, 0, 1'b0);
      // suppress is ignored for an unknown client
      push_request(32'h80000000, 32'sh0, 32'sh80000000, 32'sh0, 8'h00, 1'b0, 1'b1, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd8, 8'h7E, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh0, 32'sd9, 8'h00, 1'b1, 1'b1, 0, 1'b0);
      // keys that differ from a stored one in a single field are distinct clients
      push_request(32'h1, 32'sh80000000, 32'sh0, 32'sd8, 8'h61, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000001, 32'sh0, 32'sd8, 8'h62, 1'b0, 1'b0, 0, 1'b0);
      push_request(32'h0, 32'sh80000000, 32'sh1, 32'sd8, 8'h63, 1'b0, 1'b0, 0, 1'b0);

      // Client pool larger than the table so entries get evicted
      for (int i = 0; i < POOL_KEYS; i++) begin
         pool_addr[i] = $urandom;
         pool_inc[i]  = $urandom;
         pool_cli[i]  = $urandom;
         pool_last[i] = $urandom;
      end
      pool_addr[0] = 32'hFFFFFFFF;
      pool_inc[0]  = 32'sh7FFFFFFF;
      pool_cli[0]  = 32'sh80000000;
      pool_addr[1] = 32'h0;
      pool_inc[1]  = 32'sh80000000;
      pool_cli[1]  = 32'sh7FFFFFFF;

      // Random: mostly known clients with plausible numbers, some noise
      for (int i = 0; i < N_RANDOM; i++) begin
         gap = 0;
         if (i < N_RANDOM - N_TAIL && (i / 120) % 2 == 0 && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
         drop  = ($urandom_range(0, 11) == 0);
         quiet = ($urandom_range(0, 7) == 0);
         sel   = $urandom_range(0, 99);
         if (sel < 8) begin
            push_request($urandom, $urandom, $urandom, $urandom,
                         rdct_pkg::CHAR_W'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap,
                         i == 0 || i == N_RANDOM / 2);
         end else begin
            k = $urandom_range(0, POOL_KEYS - 1);
            if (sel < 55)      num = pool_last[k] + $urandom_range(1, 3);
            else if (sel < 70) num = pool_last[k];
            else if (sel < 85) num = pool_last[k] - $urandom_range(1, 1000);
            else if (sel < 93) num = $urandom;
            else               num = pool_last[k] + $urandom_range(1000, 1 << 30);
            if (!drop && num > pool_last[k])
               pool_last[k] = num;
            push_request(pool_addr[k], pool_inc[k], pool_cli[k], num,
                         rdct_pkg::CHAR_W'($urandom), drop, quiet,
                         gap, i == 0 || i == N_RANDOM / 2);
         end
      end
      total_items = pending.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for all requests to go out and all results to come back
      do
         @(negedge clock);
      while (pending.size() != 0 || staged_ok || req_tvalid || n_accepted != n_checked);
      repeat (40) @(posedge clock);

      if (errors == 0 && expected_replies.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: request_dedup_client_table_unit.f
rtl/core/rdct_pkg.sv
rtl/core/rdct_ctrl.sv
rtl/core/rdct_datapath.sv
rtl/core/request_dedup_client_table_unit.sv
tb/testbench.sv
